>>> hdl/tpwg_pkg.sv
// tpwg_pkg: shared constants and the quarter-sine table function
// for the tape pulse waveform generator core.
// no dependencies.
package tpwg_pkg;

	// field widths fixed by the stream format
	localparam int unsigned RATIO_WIDTH = 24;
	localparam int unsigned LEN_WIDTH   = 24;
	localparam int unsigned MUL_STEPS   = 24;

	// configuration register indexes
	localparam logic [1:0] REG_TAPE_VERSION  = 2'd0;
	localparam logic [1:0] REG_WAVE_SHAPE    = 2'd1;
	localparam logic [1:0] REG_SIGNED_OUTPUT = 2'd2;
	localparam logic [1:0] REG_RATE_RATIO    = 2'd3;

	// input word kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// wave shapes
	localparam logic SHAPE_SQUARE = 1'b0;
	localparam logic SHAPE_SINE   = 1'b1;

	// register reset values
	localparam logic                   TAPE_VERSION_RESET = 1'b1;
	localparam logic [RATIO_WIDTH-1:0] RATIO_RESET        = 24'd750953;

	// pulse constants
	localparam logic [23:0] V0_PAUSE_CYCLES = 24'd20000;
	localparam logic [6:0]  PULSE_AMP       = 7'd127;
	localparam logic [7:0]  UNSIGNED_OFFSET = 8'd128;

	// fixed-point sine constants (Q2.30)
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam int unsigned HORNER_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

	// magnitude of 127*sin(x) for x in Q2.30, Horner series, truncating
	// products and flooring divisions; used only to build the sine table
	function automatic logic [7:0] quarter_sine_mag(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] y;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int k = 0; k < 7; k++) begin
			t = Q30_ONE - (((x2 * t) >> 30) / HORNER_DIV[k]);
		end
		s = (x * t) >> 30;
		y = (64'd127 * s) >> 30;
		return (y > 64'd127) ? 8'd127 : y[7:0];
	endfunction

endpackage

>>> hdl/tape_pulse_waveform_generator_core.sv
// tape_pulse_waveform_generator_core: turns tape pulse bytes into audio
// cycles, one sample per tick, with a shared add/subtract unit.
// depends on tpwg_pkg.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata: data_byte, tuser: opcode
// m_*       out  m_tvalid/m_tready    tdata: sample, tuser: idle
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// one word at a time: s_tready is high only while the sequencer is idle.
// a tape byte that starts a pulse is taken in the accepting cycle, then runs
// the length multiply, one add per multiplier bit in the shared unit; other
// bytes are taken while the sequencer stays idle. a square or idle tick is
// presented in the cycle after it is taken; a sine tick runs 24 multiply
// steps, 1 realign, log2(SINE_STEPS) divide steps, 1 table read and the
// output state before the result word is shown.
// the result holds until m_tready and no word is taken while it waits;
// reset sets every register but the table read to its reset value, no clearing pass.
module tape_pulse_waveform_generator_core #(
	parameter int unsigned SINE_STEPS          = 4096,
	parameter int unsigned RATIO_FRACTION_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [0:0] s_tuser,   // [0] opcode
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] sample
	output logic [0:0] m_tuser,   // [0] idle
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int unsigned QB = $clog2(SINE_STEPS);
	localparam logic [63:0] STEPS64 = 64'(SINE_STEPS);
	localparam logic [63:0] HALF64  = 64'(2 * SINE_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LEN,
		ST_MUL_POS,
		ST_DIV_INIT,
		ST_DIV,
		ST_ROM_RD,
		ST_SINE_OUT,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic        tape_version_q;
	logic        wave_shape_q;
	logic        signed_output_q;
	logic [23:0] rate_ratio_q;

	// pulse state
	logic [23:0] pulse_length_q;
	logic [23:0] sample_position_q;
	logic        pulse_tone_q;
	logic        pend_tone_q;
	logic [1:0]  gather_phase_q;
	logic [23:0] pause_count_q;

	// shared unit working registers
	logic [23:0] hi_q;
	logic [23:0] lo_q;
	logic [4:0]  cnt_q;

	// output word
	logic [7:0] out_sample_q;
	logic       out_idle_q;

	// sine table: sign and magnitude for each index of the cycle
	logic [7:0] sine_rom [SINE_STEPS];
	logic [7:0] rom_q;

	for (genvar i = 0; i < SINE_STEPS; i++) begin : g_rom
		localparam logic [63:0] U4  = 64'(4 * i);
		localparam logic        NEG = (U4 >= HALF64);
		localparam logic [63:0] U1  = NEG ? (U4 - HALF64) : U4;
		localparam logic [63:0] U   = (U1 > STEPS64) ? (HALF64 - U1) : U1;
		localparam logic [63:0] X   = (tpwg_pkg::PI_HALF_Q30 * U) / STEPS64;
		localparam logic [7:0]  MAG = (U == 64'd0) ? 8'd0 :
			(U >= STEPS64) ? 8'd127 : tpwg_pkg::quarter_sine_mag(X);
		assign sine_rom[i] = {NEG, MAG[6:0]};
	end

	// registered table read
	always_ff @(posedge clk) begin
		rom_q <= sine_rom[lo_q[QB-1:0]];
	end

	// shared add/subtract unit
	logic        unit_sub;
	logic [24:0] unit_a;
	logic [23:0] unit_b;
	logic [25:0] unit_res;

	always_comb begin
		unit_a   = {1'b0, hi_q};
		unit_b   = rate_ratio_q;
		unit_sub = 1'b0;
		case (state_q)
			ST_MUL_POS: begin
				unit_b = sample_position_q;
			end
			ST_DIV: begin
				unit_a   = {hi_q, lo_q[QB-1]};
				unit_b   = pulse_length_q;
				unit_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign unit_res = {1'b0, unit_a} + (unit_sub ? ~{2'b00, unit_b} : {2'b00, unit_b})
		+ {25'd0, unit_sub};

	// multiply step: add when the multiplier bit is set, then shift right
	logic [24:0] mul_sel;
	assign mul_sel = lo_q[0] ? unit_res[24:0] : {1'b0, hi_q};

	// length from the product as it stands after the last step, saturated
	logic [47:0] prod;
	logic [47:0] prod_fin;
	logic [47:0] prod_shift;
	logic [23:0] new_len;
	assign prod       = {hi_q, lo_q};
	assign prod_fin   = {mul_sel, lo_q[23:1]};
	assign prod_shift = prod_fin >> RATIO_FRACTION_BITS;
	assign new_len    = (|prod_shift[47:24]) ? 24'hFFFFFF : prod_shift[23:0];

	// pulse status and sample forming
	logic        busy;
	logic [7:0]  offset;
	logic        sq_neg;
	logic [7:0]  sq_sample;
	logic [6:0]  sine_mag;
	logic [7:0]  sine_sample;
	logic [23:0] pos_inc;
	logic        pos_wrap;

	assign busy      = sample_position_q < pulse_length_q;
	assign offset    = signed_output_q ? 8'd0 : tpwg_pkg::UNSIGNED_OFFSET;
	assign sq_neg    = !(sample_position_q < (pulse_length_q >> 1));
	assign sq_sample = sq_neg ? (offset - {1'b0, pulse_tone_q ? tpwg_pkg::PULSE_AMP : 7'd0})
		: (offset + {1'b0, pulse_tone_q ? tpwg_pkg::PULSE_AMP : 7'd0});
	assign sine_mag    = pulse_tone_q ? rom_q[6:0] : 7'd0;
	assign sine_sample = rom_q[7] ? (offset - {1'b0, sine_mag}) : (offset + {1'b0, sine_mag});
	assign pos_inc     = sample_position_q + 24'd1;
	assign pos_wrap    = pos_inc >= pulse_length_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = out_sample_q;
	assign m_tuser  = out_idle_q;

	// sequencer, pulse state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			tape_version_q    <= tpwg_pkg::TAPE_VERSION_RESET;
			wave_shape_q      <= tpwg_pkg::SHAPE_SQUARE;
			signed_output_q   <= 1'b0;
			rate_ratio_q      <= tpwg_pkg::RATIO_RESET;
			pulse_length_q    <= '0;
			sample_position_q <= '0;
			pulse_tone_q      <= 1'b0;
			pend_tone_q       <= 1'b0;
			gather_phase_q    <= '0;
			pause_count_q     <= '0;
			hi_q              <= '0;
			lo_q              <= '0;
			cnt_q             <= '0;
			out_sample_q      <= '0;
			out_idle_q        <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					tpwg_pkg::REG_TAPE_VERSION:  tape_version_q  <= cfg_data[0];
					tpwg_pkg::REG_WAVE_SHAPE:    wave_shape_q    <= cfg_data[0];
					tpwg_pkg::REG_SIGNED_OUTPUT: signed_output_q <= cfg_data[0];
					tpwg_pkg::REG_RATE_RATIO:    rate_ratio_q    <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0] == tpwg_pkg::OP_TICK) begin
							if (!busy) begin
								out_sample_q <= offset;
								out_idle_q   <= 1'b1;
								state_q      <= ST_OUT;
							end else if (wave_shape_q == tpwg_pkg::SHAPE_SQUARE) begin
								out_sample_q <= sq_sample;
								out_idle_q   <= 1'b0;
								state_q      <= ST_OUT;
								if (pos_wrap) begin
									sample_position_q <= '0;
									pulse_length_q    <= '0;
								end else begin
									sample_position_q <= pos_inc;
								end
							end else begin
								// x * SINE_STEPS, then divide by the length
								hi_q    <= '0;
								lo_q    <= 24'(SINE_STEPS);
								cnt_q   <= '0;
								state_q <= ST_MUL_POS;
							end
						end else if (!busy) begin
							if (gather_phase_q != 2'd0) begin
								// pause count bytes, low byte first
								case (gather_phase_q)
									2'd1: begin
										pause_count_q  <= {16'd0, s_tdata};
										gather_phase_q <= 2'd2;
									end
									2'd2: begin
										pause_count_q[15:8] <= s_tdata;
										gather_phase_q      <= 2'd3;
									end
									default: begin
										pause_count_q[23:16] <= s_tdata;
										gather_phase_q       <= 2'd0;
										hi_q                 <= '0;
										lo_q                 <= {s_tdata, pause_count_q[15:0]};
										cnt_q                <= '0;
										pend_tone_q          <= 1'b0;
										state_q              <= ST_MUL_LEN;
									end
								endcase
							end else if (s_tdata != 8'd0) begin
								hi_q        <= '0;
								lo_q        <= {13'd0, s_tdata, 3'b000};
								cnt_q       <= '0;
								pend_tone_q <= 1'b1;
								state_q     <= ST_MUL_LEN;
							end else if (tape_version_q == 1'b0) begin
								hi_q        <= '0;
								lo_q        <= tpwg_pkg::V0_PAUSE_CYCLES;
								cnt_q       <= '0;
								pend_tone_q <= 1'b0;
								state_q     <= ST_MUL_LEN;
							end else begin
								gather_phase_q <= 2'd1;
							end
						end
					end
				end
				ST_MUL_LEN: begin
					hi_q  <= mul_sel[24:1];
					lo_q  <= {mul_sel[0], lo_q[23:1]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(tpwg_pkg::MUL_STEPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL_POS: begin
					hi_q  <= mul_sel[24:1];
					lo_q  <= {mul_sel[0], lo_q[23:1]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(tpwg_pkg::MUL_STEPS - 1)) begin
						state_q <= ST_DIV_INIT;
					end
				end
				ST_DIV_INIT: begin
					// partial remainder from the top bits, low bits shift in
					hi_q    <= prod[QB+23:QB];
					lo_q    <= {{(24-QB){1'b0}}, prod[QB-1:0]};
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					hi_q  <= unit_res[25] ? unit_a[23:0] : unit_res[23:0];
					lo_q  <= {lo_q[22:0], ~unit_res[25]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QB - 1)) begin
						state_q <= ST_ROM_RD;
					end
				end
				ST_ROM_RD: begin
					state_q <= ST_SINE_OUT;
				end
				ST_SINE_OUT: begin
					out_sample_q <= sine_sample;
					out_idle_q   <= 1'b0;
					state_q      <= ST_OUT;
					if (pos_wrap) begin
						sample_position_q <= '0;
						pulse_length_q    <= '0;
					end else begin
						sample_position_q <= pos_inc;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// a finished length multiply starts the pulse
			if (state_q == ST_MUL_LEN && cnt_q == 5'(tpwg_pkg::MUL_STEPS - 1)) begin
				pulse_length_q    <= new_len;
				sample_position_q <= '0;
				pulse_tone_q      <= pend_tone_q;
			end
		end
	end

endmodule
